>>> src/rgb_to_pixel_color_core_assert.svh
// assertion macros for the checker file
`ifndef RGB_TO_PIXEL_COLOR_CORE_ASSERT_SVH
`define RGB_TO_PIXEL_COLOR_CORE_ASSERT_SVH

// antecedent holds, consequent in the same cycle
`define RPC_ASSERT_SAME(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// antecedent holds, consequent in the next cycle
`define RPC_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

>>> src/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types and constants of the rgb to pixel color converter.
// ----------------------------------------------------------------------------
package rpc_pkg;

	localparam int CHAN_W            = 8;
	localparam int NUM_CHAN          = 3;
	localparam int ENTRY_W           = CHAN_W * NUM_CHAN;
	localparam int IDX_W             = 8;
	localparam int SUM_W             = 10;
	localparam int COUNT_W           = 9;
	localparam int SIZE_W            = 4;
	localparam int OFFSET_W          = 5;
	localparam int PIXEL_W           = 32;
	localparam int CFG_DATA_W        = 9;
	localparam int CFG_IDX_W         = 3;
	localparam int PALETTE_DEPTH_DEF = 256;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RED_SIZE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_SIZE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_SIZE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RED_OFFSET    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_OFFSET  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_OFFSET   = 3'd7;

	localparam logic KIND_CONVERT = 1'b0;
	localparam logic KIND_WRITE   = 1'b1;
	localparam logic MODE_DIRECT  = 1'b0;
	localparam logic MODE_PALETTE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PACK,
		ST_SEARCH
	} core_state_t;

	typedef enum logic [1:0] {
		SR_IDLE,
		SR_RUN,
		SR_DONE
	} srch_state_t;

	// one palette entry travelling down the distance chain
	typedef struct packed {
		logic               valid;
		logic               last;
		logic [IDX_W-1:0]   idx;
		logic [SUM_W-1:0]   sum;
		logic [ENTRY_W-1:0] chans;
	} rpc_cell_t;

	typedef struct packed {
		logic start;
		logic ack;
		logic wr;
	} rpc_srch_req_t;

endpackage

>>> src/rpc_dist_cell.sv
// ----------------------------------------------------------------------------
// rpc_dist_cell
// One channel of the distance chain: adds |query - entry| of the leading
// channel to the running sum and shifts the entry on to the next cell.
// ----------------------------------------------------------------------------
module rpc_dist_cell
	import rpc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [CHAN_W-1:0] qval,
	input  rpc_cell_t         din,
	output rpc_cell_t         dout
);

	logic [CHAN_W-1:0]  qval_q;
	logic               valid_q;
	logic               last_q;
	logic [IDX_W-1:0]   idx_q;
	logic [SUM_W-1:0]   sum_q;
	logic [ENTRY_W-1:0] chans_q;
	logic [CHAN_W-1:0]  ent;
	logic [CHAN_W-1:0]  diff;

	assign ent  = din.chans[ENTRY_W-1 -: CHAN_W];
	assign diff = (qval_q > ent) ? (qval_q - ent) : (ent - qval_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			qval_q <= qval;
		end
		last_q  <= din.last;
		idx_q   <= din.idx;
		sum_q   <= din.sum + SUM_W'(diff);
		chans_q <= din.chans << CHAN_W;
	end

	assign dout = '{valid: valid_q, last: last_q, idx: idx_q, sum: sum_q, chans: chans_q};

endmodule

>>> src/rpc_search.sv
// ----------------------------------------------------------------------------
// rpc_search
// Palette store and nearest-entry search: one entry read per cycle, fed
// through a chain of per-channel distance cells into a running minimum.
// ----------------------------------------------------------------------------
module rpc_search
	import rpc_pkg::*;
#(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  rpc_srch_req_t      req,
	input  logic [ENTRY_W-1:0] query,
	input  logic [COUNT_W-1:0] count,
	input  logic [IDX_W-1:0]   wr_index,
	input  logic [ENTRY_W-1:0] wr_data,
	output logic               done,
	output logic [IDX_W-1:0]   result_idx
);

	localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int CW = $clog2(PALETTE_DEPTH + 1);

	logic [ENTRY_W-1:0] mem [0:PALETTE_DEPTH-1];

	srch_state_t        state_q, state_d;
	logic [CW-1:0]      n_sat;
	logic [CW-1:0]      n_q;
	logic [CW-1:0]      issue_cnt_q;
	logic               issue;
	logic               rd_valid_s1;
	logic               rd_last_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic [ENTRY_W-1:0] rd_data_s1;
	logic [SUM_W-1:0]   best_sum_q;
	logic [IDX_W-1:0]   best_idx_q;
	rpc_cell_t          chain [0:NUM_CHAN];

	always_comb begin
		if (32'(count) > PALETTE_DEPTH) begin
			n_sat = CW'(PALETTE_DEPTH);
		end else begin
			n_sat = CW'(count);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SR_IDLE: begin
				if (req.start) begin
					state_d = (n_sat == '0) ? SR_DONE : SR_RUN;
				end
			end
			SR_RUN: begin
				if (chain[NUM_CHAN].valid && chain[NUM_CHAN].last) begin
					state_d = SR_DONE;
				end
			end
			SR_DONE: begin
				if (req.ack) begin
					state_d = SR_IDLE;
				end
			end
			default: state_d = SR_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		issue = (state_q == SR_RUN) && (issue_cnt_q < n_q);
		done  = (state_q == SR_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SR_IDLE;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr && (32'(wr_index) < PALETTE_DEPTH)) begin
			mem[wr_index[AW-1:0]] <= wr_data;
		end
		if (issue) begin
			rd_data_s1 <= mem[issue_cnt_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q         <= n_sat;
			issue_cnt_q <= '0;
		end else if (issue) begin
			issue_cnt_q <= issue_cnt_q + CW'(1);
		end
		rd_idx_s1  <= IDX_W'(issue_cnt_q[AW-1:0]);
		rd_last_s1 <= (issue_cnt_q == n_q - CW'(1));
	end

	assign chain[0] = '{valid: rd_valid_s1, last: rd_last_s1, idx: rd_idx_s1,
		sum: '0, chans: rd_data_s1};

	for (genvar k = 0; k < NUM_CHAN; k++) begin : g_cell
		rpc_dist_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (req.start),
			.qval   (query[ENTRY_W-1-k*CHAN_W -: CHAN_W]),
			.din    (chain[k]),
			.dout   (chain[k+1])
		);
	end

	// strict compare keeps the lowest index on a tie
	always_ff @(posedge clk) begin
		if (req.start) begin
			best_sum_q <= '1;
			best_idx_q <= '0;
		end else if (chain[NUM_CHAN].valid && (chain[NUM_CHAN].sum < best_sum_q)) begin
			best_sum_q <= chain[NUM_CHAN].sum;
			best_idx_q <= chain[NUM_CHAN].idx;
		end
	end

	assign result_idx = best_idx_q;

endmodule

>>> src/rgb_to_pixel_color_core.sv
// ----------------------------------------------------------------------------
// rgb_to_pixel_color_core
// Converts an 8-bit rgb triple into a packed pixel word or a palette index.
// ----------------------------------------------------------------------------
// One item at a time. A palette write leaves the block ready again right
// after its transfer. A direct-mode conversion multiplies at the transfer,
// then scales and packs into the output register. A palette search reads
// the entries searched through the single read port of the palette memory,
// one entry per cycle, into the three-cell distance chain and the compare;
// when the count is zero no entry is read. Results go out through an output
// register, so a new item is taken while the previous result waits on
// out_stall.
module rgb_to_pixel_color_core
	import rpc_pkg::*;
#(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  kind,
	input  logic [CHAN_W-1:0]     red,
	input  logic [CHAN_W-1:0]     green,
	input  logic [CHAN_W-1:0]     blue,
	input  logic [IDX_W-1:0]      entry_index,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIXEL_W-1:0]    pixel_value,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int PROD_W = 2 * CHAN_W;

	function automatic logic [CHAN_W-1:0] size_mask(input logic [SIZE_W-1:0] size);
		logic [CHAN_W:0] m;
		if (size > SIZE_W'(CHAN_W)) begin
			m = (CHAN_W+1)'(1) << CHAN_W;
		end else begin
			m = (CHAN_W+1)'(1) << size;
		end
		return CHAN_W'(m - (CHAN_W+1)'(1));
	endfunction

	// floor(x / 255), exact over the 16-bit product range
	function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
		logic [PROD_W:0] t;
		t = {1'b0, x} + (PROD_W+1)'(x[PROD_W-1:CHAN_W]) + (PROD_W+1)'(1);
		return t[PROD_W-1:CHAN_W];
	endfunction

	logic                color_mode_q;
	logic [COUNT_W-1:0]  palette_count_q;
	logic [SIZE_W-1:0]   red_size_q, green_size_q, blue_size_q;
	logic [OFFSET_W-1:0] red_offset_q, green_offset_q, blue_offset_q;

	core_state_t         state_q, state_d;
	logic                in_xfer;
	logic                slot_free;
	logic                res_ready;
	logic                load_out;
	rpc_srch_req_t       srch_req;
	logic                srch_done;
	logic [IDX_W-1:0]    srch_idx;
	logic [PROD_W-1:0]   prod_r_s1, prod_g_s1, prod_b_s1;
	logic [PIXEL_W-1:0]  packed_px;
	logic [PIXEL_W-1:0]  result;
	logic                out_valid_q;
	logic [PIXEL_W-1:0]  pixel_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q    <= MODE_DIRECT;
			palette_count_q <= '0;
			red_size_q      <= SIZE_W'(8);
			green_size_q    <= SIZE_W'(8);
			blue_size_q     <= SIZE_W'(8);
			red_offset_q    <= OFFSET_W'(16);
			green_offset_q  <= OFFSET_W'(8);
			blue_offset_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COLOR_MODE:    color_mode_q    <= cfg_data[0];
				REG_PALETTE_COUNT: palette_count_q <= cfg_data[COUNT_W-1:0];
				REG_RED_SIZE:      red_size_q      <= cfg_data[SIZE_W-1:0];
				REG_GREEN_SIZE:    green_size_q    <= cfg_data[SIZE_W-1:0];
				REG_BLUE_SIZE:     blue_size_q     <= cfg_data[SIZE_W-1:0];
				REG_RED_OFFSET:    red_offset_q    <= cfg_data[OFFSET_W-1:0];
				REG_GREEN_OFFSET:  green_offset_q  <= cfg_data[OFFSET_W-1:0];
				REG_BLUE_OFFSET:   blue_offset_q   <= cfg_data[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_xfer   = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && (kind == KIND_CONVERT)) begin
					state_d = (color_mode_q == MODE_PALETTE) ? ST_SEARCH : ST_PACK;
				end
			end
			ST_PACK: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SEARCH: begin
				if (srch_done && slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall       = (state_q != ST_IDLE);
		res_ready      = (state_q == ST_PACK) || ((state_q == ST_SEARCH) && srch_done);
		load_out       = res_ready && slot_free;
		srch_req.start = (state_q == ST_IDLE) && in_valid && (kind == KIND_CONVERT)
			&& (color_mode_q == MODE_PALETTE);
		srch_req.wr    = (state_q == ST_IDLE) && in_valid && (kind == KIND_WRITE);
		srch_req.ack   = (state_q == ST_SEARCH) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			prod_r_s1 <= PROD_W'(red) * PROD_W'(size_mask(red_size_q));
			prod_g_s1 <= PROD_W'(green) * PROD_W'(size_mask(green_size_q));
			prod_b_s1 <= PROD_W'(blue) * PROD_W'(size_mask(blue_size_q));
		end
		if (load_out) begin
			pixel_value_q <= result;
		end
	end

	assign packed_px = (PIXEL_W'(div255(prod_r_s1)) << red_offset_q)
		| (PIXEL_W'(div255(prod_g_s1)) << green_offset_q)
		| (PIXEL_W'(div255(prod_b_s1)) << blue_offset_q);

	assign result = (state_q == ST_SEARCH) ? PIXEL_W'(srch_idx) : packed_px;

	rpc_search #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_search (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (srch_req),
		.query      ({red, green, blue}),
		.count      (palette_count_q),
		.wr_index   (entry_index),
		.wr_data    ({red, green, blue}),
		.done       (srch_done),
		.result_idx (srch_idx)
	);

	assign out_valid   = out_valid_q;
	assign pixel_value = pixel_value_q;

endmodule

>>> src/rpc_checker.sv
// ----------------------------------------------------------------------------
// rpc_checker
// Port-level checks of the rgb to pixel color converter, bound to the core.
// ----------------------------------------------------------------------------
`include "rgb_to_pixel_color_core_assert.svh"

module rpc_checker
	import rpc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  kind,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [PIXEL_W-1:0]    pixel_value
);

	// a stalled result stays offered and unchanged
	`RPC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`RPC_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(pixel_value))
	// a conversion keeps the input side busy in the following cycle
	`RPC_ASSERT_NEXT(a_convert_busy, clk, arst_n,
		in_valid && !in_stall && (kind == KIND_CONVERT), in_stall)
	// a palette write transfer leaves the block ready again
	`RPC_ASSERT_NEXT(a_write_ready, clk, arst_n,
		in_valid && !in_stall && (kind == KIND_WRITE), !in_stall)

endmodule

bind rgb_to_pixel_color_core rpc_checker u_rpc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.kind        (kind),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.pixel_value (pixel_value)
);

>>> tb/rgb_to_pixel_color_core_tb.sv
// ----------------------------------------------------------------------------
// rgb_to_pixel_color_core_tb
// Self-checking bench for the rgb to pixel color converter. Color and palette
// write transfers come from a queue with bursty timing while the result side
// stalls on its own pattern. A shadow of the registers and palette predicts
// each packed pixel or nearest palette index, checked in order as it arrives.
// ----------------------------------------------------------------------------
module rgb_to_pixel_color_core_tb;
	import rpc_pkg::*;

	localparam int N_ITEMS   = 1350;
	localparam int SETTLE    = 32;
	localparam int END_WAIT  = PALETTE_DEPTH_DEF + 16;
	localparam int CYC_LIMIT = 2000000;

	typedef struct {
		logic             kind;
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
		logic [IDX_W-1:0]  idx;
	} color_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  kind = KIND_CONVERT;
	logic [CHAN_W-1:0]     red = '0;
	logic [CHAN_W-1:0]     green = '0;
	logic [CHAN_W-1:0]     blue = '0;
	logic [IDX_W-1:0]      entry_index = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [PIXEL_W-1:0]    pixel_value;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// register shadow, reset values
	logic                cfg_mode = MODE_DIRECT;
	logic [COUNT_W-1:0]  cfg_count = '0;
	logic [SIZE_W-1:0]   cfg_rsize = 4'd8;
	logic [SIZE_W-1:0]   cfg_gsize = 4'd8;
	logic [SIZE_W-1:0]   cfg_bsize = 4'd8;
	logic [OFFSET_W-1:0] cfg_roff = 5'd16;
	logic [OFFSET_W-1:0] cfg_goff = 5'd8;
	logic [OFFSET_W-1:0] cfg_boff = 5'd0;

	logic [ENTRY_W-1:0] pal_shadow [PALETTE_DEPTH_DEF];
	bit [PALETTE_DEPTH_DEF-1:0] written_mask = '0;

	color_req_t        req_q[$];
	logic [PIXEL_W-1:0] pixel_exp_q[$];

	int unsigned n_sent = 0;
	int unsigned n_taken = 0;
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	int unsigned stall_run = 0;
	bit          drain_req = 1'b0;
	bit          send_gappy = 1'b0;
	int unsigned recv_style = 0;
	int unsigned n_gen = 0;
	int unsigned n_err = 0;
	int unsigned cyc = 0;

	rgb_to_pixel_color_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.entry_index (entry_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_value (pixel_value),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= CYC_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [PIXEL_W-1:0] got,
			input logic [PIXEL_W-1:0] want);
		if (n_err < 64)
			$display("ERROR %s: got %08h, expected %08h", what, got, want);
		n_err++;
	endtask

	function automatic int unsigned chan_dist(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
		return (a > b) ? int'(a - b) : int'(b - a);
	endfunction

	function automatic logic [PIXEL_W-1:0] nearest_index(logic [CHAN_W-1:0] r,
			logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
		int unsigned n;
		int unsigned best;
		int unsigned d;
		logic [PIXEL_W-1:0] best_i;
		n = (cfg_count > PALETTE_DEPTH_DEF) ? PALETTE_DEPTH_DEF : cfg_count;
		best = '1;
		best_i = '0;
		for (int unsigned i = 0; i < n; i++) begin
			d = chan_dist(r, pal_shadow[i][23:16]) + chan_dist(g, pal_shadow[i][15:8])
				+ chan_dist(b, pal_shadow[i][7:0]);
			// strict compare keeps the lowest index on a tie
			if (d < best) begin
				best = d;
				best_i = i;
			end
		end
		return best_i;
	endfunction

	function automatic logic [PIXEL_W-1:0] pack_field(logic [CHAN_W-1:0] v,
			logic [SIZE_W-1:0] size, logic [OFFSET_W-1:0] off);
		int unsigned s;
		int unsigned scaled;
		logic [PIXEL_W-1:0] w;
		s = (size > 8) ? 8 : size;
		scaled = (int'(v) * ((32'd1 << s) - 1)) / 255;
		w = scaled;
		return w << off;
	endfunction

	task automatic predict_pixel(input color_req_t q);
		if (q.kind == KIND_WRITE) begin
			pal_shadow[q.idx] = {q.r, q.g, q.b};
		end else if (cfg_mode == MODE_PALETTE) begin
			pixel_exp_q.push_back(nearest_index(q.r, q.g, q.b));
		end else begin
			pixel_exp_q.push_back(pack_field(q.r, cfg_rsize, cfg_roff)
				| pack_field(q.g, cfg_gsize, cfg_goff)
				| pack_field(q.b, cfg_bsize, cfg_boff));
		end
	endtask

	// input side: bursts, gaps and the odd pause until all results are back
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && n_taken != n_sent) begin
			// stalled transfer, hold payload
		end else if (gap_left != 0) begin
			gap_left <= gap_left - 1;
			in_valid <= 1'b0;
		end else if (drain_req) begin
			in_valid <= 1'b0;
			if (pixel_exp_q.size() == 0)
				drain_req <= 1'b0;
		end else if (req_q.size() != 0) begin
			in_valid <= 1'b1;
			kind <= req_q[0].kind;
			red <= req_q[0].r;
			green <= req_q[0].g;
			blue <= req_q[0].b;
			entry_index <= req_q[0].idx;
			n_sent <= n_sent + 1;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(24, 1);
				gap_left <= send_gappy ? $urandom_range(10, 0) : 0;
				if ($urandom_range(63, 0) == 0)
					drain_req <= 1'b1;
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// result side stall pattern
	always @(negedge clk) begin
		if (stall_run != 0) begin
			stall_run <= stall_run - 1;
		end else begin
			case (recv_style)
				0: begin
					out_stall <= 1'b0;
					stall_run <= $urandom_range(31, 0);
				end
				1: begin
					out_stall <= ($urandom_range(2, 0) == 0);
					stall_run <= 0;
				end
				default: begin
					out_stall <= !out_stall;
					stall_run <= out_stall ? $urandom_range(6, 0) : $urandom_range(19, 0);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		color_req_t q;
		logic [PIXEL_W-1:0] want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				q = req_q.pop_front();
				predict_pixel(q);
				n_taken <= n_taken + 1;
			end
			if (out_valid && !out_stall) begin
				if (pixel_exp_q.size() == 0) begin
					report_mismatch("unexpected result", pixel_value, '0);
				end else begin
					want = pixel_exp_q.pop_front();
					if (pixel_value !== want)
						report_mismatch("pixel_value", pixel_value, want);
				end
			end
		end
	end

	task automatic push_convert(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
			input logic [CHAN_W-1:0] b);
		color_req_t q;
		q.kind = KIND_CONVERT;
		q.r = r;
		q.g = g;
		q.b = b;
		q.idx = IDX_W'($urandom_range(255, 0));
		req_q.push_back(q);
		n_gen++;
	endtask

	task automatic push_write(input logic [IDX_W-1:0] idx, input logic [CHAN_W-1:0] r,
			input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
		color_req_t q;
		q.kind = KIND_WRITE;
		q.r = r;
		q.g = g;
		q.b = b;
		q.idx = idx;
		req_q.push_back(q);
		written_mask[idx] = 1'b1;
		n_gen++;
	endtask

	function automatic logic [CHAN_W-1:0] rand_chan();
		case ($urandom_range(9, 0))
			0: return 8'd0;
			1: return 8'd255;
			default: return CHAN_W'($urandom_range(255, 0));
		endcase
	endfunction

	// palette data drawn partly from a coarse grid so that distance ties occur
	function automatic logic [CHAN_W-1:0] rand_pal_chan();
		if ($urandom_range(1, 0) == 0)
			return 8'(64 * $urandom_range(4, 0) - (($urandom_range(1, 0) == 0) ? 0 : 1));
		return CHAN_W'($urandom_range(255, 0));
	endfunction

	task automatic wait_idle(input int unsigned extra);
		while (req_q.size() != 0 || in_valid || pixel_exp_q.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		case (idx)
			REG_COLOR_MODE:    cfg_mode = val[0];
			REG_PALETTE_COUNT: cfg_count = val[COUNT_W-1:0];
			REG_RED_SIZE:      cfg_rsize = val[SIZE_W-1:0];
			REG_GREEN_SIZE:    cfg_gsize = val[SIZE_W-1:0];
			REG_BLUE_SIZE:     cfg_bsize = val[SIZE_W-1:0];
			REG_RED_OFFSET:    cfg_roff = val[OFFSET_W-1:0];
			REG_GREEN_OFFSET:  cfg_goff = val[OFFSET_W-1:0];
			REG_BLUE_OFFSET:   cfg_boff = val[OFFSET_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic mode, input int unsigned count,
			input int unsigned rs, input int unsigned gs, input int unsigned bs,
			input int unsigned ro, input int unsigned go, input int unsigned bo);
		wait_idle(SETTLE);
		write_reg(REG_COLOR_MODE, mode);
		write_reg(REG_PALETTE_COUNT, count);
		write_reg(REG_RED_SIZE, rs);
		write_reg(REG_GREEN_SIZE, gs);
		write_reg(REG_BLUE_SIZE, bs);
		write_reg(REG_RED_OFFSET, ro);
		write_reg(REG_GREEN_OFFSET, go);
		write_reg(REG_BLUE_OFFSET, bo);
		send_gappy = ($urandom_range(2, 0) != 0);
		recv_style = $urandom_range(2, 0);
	endtask

	initial begin
		logic        mode;
		int unsigned count;
		int unsigned n_used;
		int unsigned len;
		int unsigned phase;
		int unsigned hi_idx;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset register values, direct mode
		push_convert(8'd0, 8'd0, 8'd0);
		push_convert(8'd255, 8'd255, 8'd255);
		push_convert(8'd1, 8'd128, 8'd254);
		push_convert(8'd255, 8'd0, 8'd0);

		// zero size, clamped size, fields shifted past the top bit
		configure(MODE_DIRECT, 0, 0, 15, 8, 31, 30, 0);
		push_convert(8'd255, 8'd255, 8'd255);
		push_convert(8'd128, 8'd1, 8'd200);
		configure(MODE_DIRECT, 0, 1, 9, 3, 0, 29, 31);
		push_convert(8'd255, 8'd255, 8'd255);
		push_convert(8'd127, 8'd200, 8'd128);

		push_write(8'd0, 8'd0, 8'd0, 8'd0);
		push_write(8'd1, 8'd255, 8'd255, 8'd255);
		push_write(8'd2, 8'd0, 8'd0, 8'd0);
		push_write(8'd3, 8'd128, 8'd128, 8'd128);
		push_write(8'd255, 8'd255, 8'd0, 8'd255);

		// empty palette answers index zero
		configure(MODE_PALETTE, 0, 8, 8, 8, 16, 8, 0);
		push_convert(8'd10, 8'd20, 8'd30);
		push_convert(8'd255, 8'd255, 8'd255);

		// ties go to the lowest index
		configure(MODE_PALETTE, 4, 8, 8, 8, 16, 8, 0);
		push_convert(8'd64, 8'd64, 8'd64);
		push_convert(8'd255, 8'd255, 8'd255);
		push_convert(8'd0, 8'd0, 8'd0);
		push_convert(8'd200, 8'd128, 8'd100);

		phase = 0;
		while (n_gen < N_ITEMS) begin
			mode = 1'($urandom_range(1, 0));
			count = ($urandom_range(9, 0) == 0) ? 0 :
				($urandom_range(5, 0) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
			case (phase % 8)
				1: begin
					mode = MODE_PALETTE;
					count = PALETTE_DEPTH_DEF;
				end
				3: begin
					// count beyond the palette size saturates
					mode = MODE_PALETTE;
					count = 511;
				end
				5: begin
					mode = MODE_PALETTE;
					count = PALETTE_DEPTH_DEF - 1;
				end
				default: ;
			endcase
			if (phase % 8 == 7)
				configure(MODE_DIRECT, count, 15, 0, 8, 31, 0, 24);
			else
				configure(mode, count,
					($urandom_range(4, 0) == 0) ? $urandom_range(15, 9) : $urandom_range(8, 0),
					($urandom_range(4, 0) == 0) ? $urandom_range(15, 9) : $urandom_range(8, 0),
					($urandom_range(4, 0) == 0) ? $urandom_range(15, 9) : $urandom_range(8, 0),
					$urandom_range(31, 0), $urandom_range(31, 0), $urandom_range(31, 0));

			n_used = (count > PALETTE_DEPTH_DEF) ? PALETTE_DEPTH_DEF : count;
			if (cfg_mode == MODE_PALETTE) begin
				// every searched entry is loaded before the first lookup
				for (int unsigned i = 0; i < n_used; i++)
					if (!written_mask[i])
						push_write(IDX_W'(i), rand_pal_chan(), rand_pal_chan(),
							rand_pal_chan());
			end

			len = (cfg_mode == MODE_PALETTE && n_used > 64) ?
				$urandom_range(12, 6) : $urandom_range(60, 20);
			hi_idx = (n_used == 0) ? 0 : n_used - 1;
			for (int unsigned k = 0; k < len; k++) begin
				if ($urandom_range(99, 0) < 12)
					push_write(IDX_W'(($urandom_range(1, 0) == 0) ?
						$urandom_range(hi_idx, 0) : $urandom_range(255, 0)),
						rand_pal_chan(), rand_pal_chan(), rand_pal_chan());
				else if (cfg_mode == MODE_PALETTE && $urandom_range(2, 0) == 0)
					push_convert(rand_pal_chan(), rand_pal_chan(), rand_pal_chan());
				else
					push_convert(rand_chan(), rand_chan(), rand_chan());
			end
			phase++;
		end

		wait_idle(END_WAIT);
		if (pixel_exp_q.size() != 0)
			report_mismatch("missing result", '0, pixel_exp_q[0]);
		if (n_err == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
